[rtl/core/seud_pkg.sv]
// ----------------------------------------------------------------------------
// seud_pkg
// Types, character codes and helper functions shared by the string literal
// unescape and UTF-8 encode block.
// ----------------------------------------------------------------------------
package seud_pkg;

   // Decoder modes of the front end
   typedef enum logic [2:0] {
      MODE_WAIT   = 3'd0,
      MODE_BODY   = 3'd1,
      MODE_ESC    = 3'd2,
      MODE_XOCT   = 3'd3,
      MODE_XHEX   = 3'd4,
      MODE_UBRACE = 3'd5,
      MODE_UDIG   = 3'd6
   } mode_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_INVALID_CP = 2'd1,
      STATUS_BAD_ESCAPE = 2'd2
   } status_type;

   // Character codes
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_APOS      = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_F   = 8'h46;
   localparam logic [7:0] CH_N         = 8'h6e;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_LBRACE    = 8'h7b;
   localparam logic [7:0] CH_RBRACE    = 8'h7d;

   // Control byte values produced by escapes
   localparam logic [7:0] BYTE_LF  = 8'h0a;
   localparam logic [7:0] BYTE_CR  = 8'h0d;
   localparam logic [7:0] BYTE_TAB = 8'h09;

   // Code point limits
   localparam logic [31:0] CP_MAX        = 32'h0010_ffff;
   localparam logic [31:0] CP_SURR_LO    = 32'h0000_d800;
   localparam logic [31:0] CP_SURR_HI    = 32'h0000_dfff;
   localparam logic [31:0] CP_TWO_BYTE   = 32'h0000_0080;
   localparam logic [31:0] CP_THREE_BYTE = 32'h0000_0800;
   localparam logic [31:0] CP_FOUR_BYTE  = 32'h0001_0000;

   // UTF-8 lead and continuation prefixes
   localparam logic [2:0] LEAD2_PREFIX = 3'b110;
   localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
   localparam logic [4:0] LEAD4_PREFIX = 5'b11110;
   localparam logic [1:0] CONT_PREFIX  = 2'b10;

   // One burst of results caused by a single input character
   typedef struct packed {
      logic [2:0]      count;       // 1 to 4 results
      logic [3:0][7:0] bytes;       // bytes[0] goes out first
      logic            has_byte;
      logic            literal_end;
      status_type      status;
   } burst_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Hex digit decode: {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         r = {1'b1, 4'(c - CH_ZERO)};
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
      end
      return r;
   endfunction

   // Encode a valid code point as 1 to 4 UTF-8 bytes
   function automatic burst_type utf8_encode(input logic [31:0] cp);
      burst_type b;
      b = '0;
      b.has_byte = 1'b1;
      b.status   = STATUS_OK;
      if (cp < CP_TWO_BYTE) begin
         b.count    = 3'd1;
         b.bytes[0] = cp[7:0];
      end else if (cp < CP_THREE_BYTE) begin
         b.count    = 3'd2;
         b.bytes[0] = {LEAD2_PREFIX, cp[10:6]};
         b.bytes[1] = {CONT_PREFIX, cp[5:0]};
      end else if (cp < CP_FOUR_BYTE) begin
         b.count    = 3'd3;
         b.bytes[0] = {LEAD3_PREFIX, cp[15:12]};
         b.bytes[1] = {CONT_PREFIX, cp[11:6]};
         b.bytes[2] = {CONT_PREFIX, cp[5:0]};
      end else begin
         b.count    = 3'd4;
         b.bytes[0] = {LEAD4_PREFIX, cp[20:18]};
         b.bytes[1] = {CONT_PREFIX, cp[17:12]};
         b.bytes[2] = {CONT_PREFIX, cp[11:6]};
         b.bytes[3] = {CONT_PREFIX, cp[5:0]};
      end
      return b;
   endfunction

endpackage

[rtl/core/seud_front.sv]
// ----------------------------------------------------------------------------
// seud_front
// Accepts one raw character per beat, runs the escape state machine and
// pushes a burst descriptor into the queue for every character that makes
// results.
// ----------------------------------------------------------------------------
module seud_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                ch,
   output logic                      push,
   output seud_pkg::burst_type       burst
);
   import seud_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [2:0]  digit_ff, digit_in;
   logic [31:0] accum_ff, accum_in;
   logic        emit;
   logic [4:0]  hex;
   logic [31:0] cp;

   assign hex = hex_value(ch);
   assign cp  = accum_ff;

   // Hold state until a beat is accepted
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_WAIT;
         digit_ff <= '0;
         accum_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         digit_ff <= digit_in;
         accum_ff <= accum_in;
      end
   end

   // Classify the character and build its burst
   always_comb begin
      mode_in  = mode_ff;
      digit_in = digit_ff;
      accum_in = accum_ff;
      emit     = 1'b0;
      burst    = '0;
      burst.count  = 3'd1;
      burst.status = STATUS_OK;
      unique case (mode_ff)
         MODE_WAIT: begin
            if (ch == CH_QUOTE) mode_in = MODE_BODY;
         end
         MODE_BODY: begin
            if (ch == CH_QUOTE) begin
               emit              = 1'b1;
               burst.literal_end = 1'b1;
               mode_in           = MODE_WAIT;
            end else if (ch == CH_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               emit           = 1'b1;
               burst.has_byte = 1'b1;
               burst.bytes[0] = ch;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_BODY;
            unique case (ch) inside
               CH_N: begin
                  emit = 1'b1; burst.has_byte = 1'b1; burst.bytes[0] = BYTE_LF;
               end
               CH_R: begin
                  emit = 1'b1; burst.has_byte = 1'b1; burst.bytes[0] = BYTE_CR;
               end
               CH_T: begin
                  emit = 1'b1; burst.has_byte = 1'b1; burst.bytes[0] = BYTE_TAB;
               end
               CH_QUOTE, CH_APOS, CH_BACKSLASH: begin
                  emit = 1'b1; burst.has_byte = 1'b1; burst.bytes[0] = ch;
               end
               CH_ZERO: begin
                  emit = 1'b1; burst.has_byte = 1'b1;
               end
               CH_X: mode_in = MODE_XOCT;
               CH_U: mode_in = MODE_UBRACE;
               default: begin
                  emit = 1'b1; burst.status = STATUS_BAD_ESCAPE;
               end
            endcase
         end
         MODE_XOCT: begin
            mode_in = MODE_XHEX;
            if (ch >= CH_ZERO && ch <= CH_SEVEN) begin
               digit_in = ch[2:0];
            end else begin
               digit_in     = '0;
               emit         = 1'b1;
               burst.status = STATUS_BAD_ESCAPE;
            end
         end
         MODE_XHEX: begin
            mode_in        = MODE_BODY;
            emit           = 1'b1;
            burst.has_byte = 1'b1;
            burst.bytes[0] = {1'b0, digit_ff, hex[4] ? hex[3:0] : 4'd0};
            burst.status   = hex[4] ? STATUS_OK : STATUS_BAD_ESCAPE;
         end
         MODE_UBRACE: begin
            accum_in = '0;
            mode_in  = MODE_UDIG;
            if (ch != CH_LBRACE) begin
               emit         = 1'b1;
               burst.status = STATUS_BAD_ESCAPE;
            end
         end
         MODE_UDIG: begin
            if (ch == CH_RBRACE) begin
               emit     = 1'b1;
               accum_in = '0;
               mode_in  = MODE_BODY;
               if (cp > CP_MAX || (cp >= CP_SURR_LO && cp <= CP_SURR_HI)) begin
                  burst.status = STATUS_INVALID_CP;
               end else begin
                  burst = utf8_encode(cp);
               end
            end else if (hex[4]) begin
               // Wrap at 32 bits
               accum_in = {accum_ff[27:0], hex[3:0]};
            end
         end
         default: mode_in = MODE_WAIT;
      endcase
   end

   assign push = accept && emit;

   // The code point register is only in use inside a brace escape
   a_accum_idle: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_UDIG |-> accum_ff == '0)
      else $error("code point accumulator not clear outside brace escape");

   a_burst_count: assert property (@(posedge clock) disable iff (reset)
      push |-> (burst.count != 3'd0 && burst.count <= 3'd4))
      else $error("burst count out of range");

   a_bytes_flag: assert property (@(posedge clock) disable iff (reset)
      push && !burst.has_byte |-> burst.count == 3'd1)
      else $error("byteless burst with several results");

endmodule

[rtl/core/seud_queue.sv]
// ----------------------------------------------------------------------------
// seud_queue
// Short FIFO of burst descriptors between the front and the back, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module seud_queue #(
   parameter int Depth = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  seud_pkg::burst_type           push_data,
   input  logic                          pop,
   output seud_pkg::burst_type           head,
   output seud_pkg::queue_status_type    qstat
);
   import seud_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   burst_type           entry_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   // Write the pushed descriptor
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head        = entry_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == CntW'(Depth));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && qstat.empty))
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count above depth");

endmodule

[rtl/core/seud_back.sv]
// ----------------------------------------------------------------------------
// seud_back
// Walks the head burst into the output register, one result per cycle
// unless the output stalls, and pops the descriptor with its last result.
// ----------------------------------------------------------------------------
module seud_back (
   input  logic                          clock,
   input  logic                          reset,
   input  seud_pkg::burst_type           head,
   input  seud_pkg::queue_status_type    qstat,
   output logic                          pop,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_data_byte,
   output logic                          rsp_has_byte,
   output logic                          rsp_last,
   output logic                          rsp_literal_end,
   output logic [1:0]                    rsp_status
);
   import seud_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  idx_ff, idx_in;
   logic [7:0]  byte_ff;
   logic        has_ff, last_ff, end_ff;
   status_type  status_ff;
   logic        load_ok, take, at_last;

   assign load_ok = !valid_ff || !rsp_stall;
   assign take    = load_ok && !qstat.empty;
   assign at_last = ({1'b0, idx_ff} == head.count - 3'd1);
   assign pop     = take && at_last;

   // Step through the burst
   always_comb begin
      valid_in = load_ok ? !qstat.empty : valid_ff;
      idx_in   = idx_ff;
      if (take) idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // Load the output beat
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff   <= head.bytes[idx_ff];
         has_ff    <= head.has_byte;
         last_ff   <= at_last;
         end_ff    <= head.literal_end;
         status_ff <= head.status;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_data_byte   = byte_ff;
   assign rsp_has_byte    = has_ff;
   assign rsp_last        = last_ff;
   assign rsp_literal_end = end_ff;
   assign rsp_status      = status_ff;

   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      !qstat.empty |-> {1'b0, idx_ff} < head.count)
      else $error("result index beyond burst");

   a_idx_rest: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> idx_ff == 2'd0)
      else $error("result index left over with empty queue");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
      $stable({rsp_data_byte, rsp_has_byte, rsp_last, rsp_literal_end, rsp_status}))
      else $error("stalled result beat changed");

endmodule

[rtl/core/string_escape_utf8_decoder_top.sv]
// ----------------------------------------------------------------------------
// string_escape_utf8_decoder_top
// Decodes double-quoted string literals one character per beat, resolving
// escapes and emitting UTF-8 bytes for brace code point escapes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   ch
//  rsp_      out        rsp_valid/rsp_stall   data_byte, has_byte, last,
//                                             literal_end, status
//
//  One character is taken per cycle while the descriptor queue has room.
//  A character makes 0 to 4 results; the back end sends one result per
//  cycle when not stalled, so a four-byte code point gives four results.
//  Each input passes the queue entry, then the output register.
//  Reset is synchronous; it returns the decoder to waiting for a quote and
//  empties the queue. A stalled output only backs up the queue; the input
//  stalls once QUEUE_DEPTH descriptors are waiting.
// ----------------------------------------------------------------------------
module string_escape_utf8_decoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_has_byte,
   output logic        rsp_last,
   output logic        rsp_literal_end,
   output logic [1:0]  rsp_status
);
   import seud_pkg::*;

   logic             accept, push, pop;
   burst_type        burst, head;
   queue_status_type qstat;

   // Stall input only on a full queue
   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;

   seud_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ch     (req_ch),
      .push   (push),
      .burst  (burst)
   );

   seud_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (burst),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   seud_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_last        (rsp_last),
      .rsp_literal_end (rsp_literal_end),
      .rsp_status      (rsp_status)
   );

endmodule
